>>> rtl/rmst_pkg.sv
// Package: item types, codes and walker states for the range-minimum segment tree.
package rmst_pkg;

  // Width and reset value of the length register
  localparam int unsigned LEN_BITS  = 11;
  localparam logic [LEN_BITS-1:0] LEN_RESET = 11'd1024;

  // Field widths fixed by the item format
  localparam int unsigned IDX_BITS  = 10;
  localparam int unsigned DATA_BITS = 32;

  // Command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                        cmd;
    logic [IDX_BITS-1:0]         position;
    logic signed [DATA_BITS-1:0] element_value;
    logic [IDX_BITS-1:0]         range_left;
    logic [IDX_BITS-1:0]         range_right;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_BITS-1:0] minimum;
    logic                        empty_range;
  } out_item_t;

  // Tree walker states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_QRY,
    ST_QOUT
  } walk_state_t;

endpackage

>>> rtl/range_minimum_segment_tree_top.sv
// Top level of the range-minimum segment tree: length register, walker, node store, result reg.
//
//  port group  | dir | handshake           | payload
//  ------------+-----+---------------------+---------------------------------------
//  in_*        | in  | in_valid / in_ready | in_item_t: cmd, position, value, range
//  out_*       | out | out_valid/out_ready | out_item_t: minimum, empty_range
//  cfg_*       | in  | cfg_wr_en           | cfg_wr_data: length (11 bits)
//
// A load writes one node store entry per tree level from the leaf up to the root,
// with one sibling read ahead. A query goes through the accept, up to two node
// reads per level over log2(MAX_LEN) + 1 levels, a closing step that folds in the
// last reads, then the result.
// After reset a clearing pass writes all 2*MAX_LEN nodes, one per cycle, before
// in_ready rises. The result register takes a result while out_ready is low only
// when it is empty; a full register stalls the walker.
module range_minimum_segment_tree_top import rmst_pkg::*; #(
  parameter int unsigned MAX_LEN    = 1024,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data,
  input  logic                cfg_wr_en,
  input  logic [LEN_BITS-1:0] cfg_wr_data
);

  localparam int unsigned NW = $clog2(2 * MAX_LEN);
  localparam logic [VALUE_BITS-1:0] LARGEST = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [63:0] LARGEST_EXT = 64'(LARGEST);
  localparam logic [DATA_BITS-1:0] LARGEST_OUT = LARGEST_EXT[DATA_BITS-1:0];

  logic [LEN_BITS-1:0]   length_r, length_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  logic                  res_valid, res_ready;
  out_item_t             res_data;
  logic                  mem_wr_en;
  logic [NW-1:0]         mem_wr_addr, mem_rd_a_addr, mem_rd_b_addr;
  logic [VALUE_BITS-1:0] mem_wr_data, mem_rd_a_data, mem_rd_b_data;

  // Length register
  assign length_nxt = cfg_wr_en ? cfg_wr_data : length_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r <= LEN_RESET;
    end else begin
      length_r <= length_nxt;
    end
  end

  // Result register
  assign res_ready     = !out_valid_r || out_ready;
  assign out_valid_nxt = (res_valid && res_ready) ? 1'b1 :
                         (out_ready ? 1'b0 : out_valid_r);
  assign out_data_nxt  = (res_valid && res_ready) ? res_data : out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  rmst_walker #(
    .MAX_LEN    (MAX_LEN),
    .VALUE_BITS (VALUE_BITS),
    .NW         (NW)
  ) u_walker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .len_i         (length_r),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res_data      (res_data),
    .mem_wr_en     (mem_wr_en),
    .mem_wr_addr   (mem_wr_addr),
    .mem_wr_data   (mem_wr_data),
    .mem_rd_a_addr (mem_rd_a_addr),
    .mem_rd_b_addr (mem_rd_b_addr),
    .mem_rd_a_data (mem_rd_a_data),
    .mem_rd_b_data (mem_rd_b_data)
  );

  rmst_node_mem #(
    .DEPTH (2 * MAX_LEN),
    .AW    (NW),
    .DW    (VALUE_BITS)
  ) u_node_mem (
    .clk       (clk),
    .wr_en     (mem_wr_en),
    .wr_addr   (mem_wr_addr),
    .wr_data   (mem_wr_data),
    .rd_a_addr (mem_rd_a_addr),
    .rd_b_addr (mem_rd_b_addr),
    .rd_a_data (mem_rd_a_data),
    .rd_b_data (mem_rd_b_data)
  );

  // A load never yields a result on the next cycle
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.cmd == CMD_LOAD) |=> !res_valid)
    else $error("result raised after a load item");

  // The walker never offers a result while it takes a new item
  a_ready_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !res_valid)
    else $error("result offered while walker idle");

  // An empty range always reports the largest value
  a_empty_largest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.empty_range |-> out_data.minimum == LARGEST_OUT)
    else $error("empty range with a non-largest minimum");

  // A result handed over lands in the result register
  a_res_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |=> out_valid && (out_data == $past(res_data)))
    else $error("result lost between walker and result register");

endmodule

>>> rtl/rmst_node_mem.sv
// Node store: one write port, two read ports, registered read data.
module rmst_node_mem #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11,
  parameter int unsigned DW    = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_a_addr,
  input  logic [AW-1:0] rd_b_addr,
  output logic [DW-1:0] rd_a_data,
  output logic [DW-1:0] rd_b_data
);

  logic [DW-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read ports, registered read data
  always_ff @(posedge clk) begin
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

>>> rtl/rmst_walker.sv
// Tree walker: clearing pass, leaf-to-root update and range query over the node store.
module rmst_walker import rmst_pkg::*; #(
  parameter int unsigned MAX_LEN    = 1024,
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned NW         = 11
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  input  logic [LEN_BITS-1:0]   len_i,
  output logic                  res_valid,
  input  logic                  res_ready,
  output out_item_t             res_data,
  output logic                  mem_wr_en,
  output logic [NW-1:0]         mem_wr_addr,
  output logic [VALUE_BITS-1:0] mem_wr_data,
  output logic [NW-1:0]         mem_rd_a_addr,
  output logic [NW-1:0]         mem_rd_b_addr,
  input  logic [VALUE_BITS-1:0] mem_rd_a_data,
  input  logic [VALUE_BITS-1:0] mem_rd_b_data
);

  localparam int unsigned PW = NW + 1;
  localparam int unsigned EW = (PW > LEN_BITS) ? PW : LEN_BITS;
  localparam logic [EW-1:0] MAXL_E = EW'(MAX_LEN);
  localparam logic [PW-1:0] MAXL_P = PW'(MAX_LEN);
  localparam logic [NW-1:0] LAST_NODE = NW'(2 * MAX_LEN - 1);
  localparam logic [NW-1:0] ROOT = NW'(1);
  localparam logic [VALUE_BITS-1:0] LARGEST = {1'b0, {(VALUE_BITS-1){1'b1}}};

  walk_state_t state_r, state_nxt;

  logic [NW-1:0]                clr_r, clr_nxt;
  logic [NW-1:0]                cur_r, cur_nxt;
  logic signed [VALUE_BITS-1:0] val_r, val_nxt;
  logic [PW-1:0]                lo_r, lo_nxt;
  logic [PW-1:0]                hi_r, hi_nxt;
  logic signed [VALUE_BITS-1:0] acc_r, acc_nxt;
  logic                         pend_a_r, pend_a_nxt;
  logic                         pend_b_r, pend_b_nxt;
  logic                         empty_r, empty_nxt;

  // Decode of the incoming item
  logic [EW-1:0]                len_e, len_c, left_e, right_e, right_c, pos_e;
  logic                         q_empty, ld_ok;
  logic [PW-1:0]                lo_init, hi_init;
  logic [NW-1:0]                leaf;
  logic signed [63:0]           val_ext;
  logic signed [VALUE_BITS-1:0] val_w;

  // Walk datapath
  logic signed [VALUE_BITS-1:0] rd_a, rd_b, upd_min, m1, m2;
  logic [NW-1:0]                parent;
  logic [PW-1:0]                hi_m1;
  logic                         more;
  logic signed [63:0]           acc_ext;

  assign rd_a = mem_rd_a_data;
  assign rd_b = mem_rd_b_data;

  // Clip the range against the length, form the leaf bounds and decode the load leaf
  always_comb begin
    len_e   = EW'(len_i);
    len_c   = (len_e > MAXL_E) ? MAXL_E : len_e;
    left_e  = EW'(in_data.range_left);
    right_e = EW'(in_data.range_right);
    right_c = (right_e > len_c - EW'(1)) ? len_c - EW'(1) : right_e;
    q_empty = (len_c == '0) || (left_e > right_c);
    lo_init = q_empty ? '0 : PW'(left_e) + MAXL_P;
    hi_init = q_empty ? '0 : PW'(right_c) + MAXL_P + PW'(1);
    pos_e   = EW'(in_data.position);
    ld_ok   = pos_e < MAXL_E;
    leaf    = NW'(pos_e + MAXL_E);
    val_ext = 64'(in_data.element_value);
    val_w   = val_ext[VALUE_BITS-1:0];
  end

  // Min of the child path value and its sibling, min-accumulate of query reads
  always_comb begin
    parent  = cur_r >> 1;
    upd_min = (rd_a < val_r) ? rd_a : val_r;
    m1      = (pend_a_r && (rd_a < acc_r)) ? rd_a : acc_r;
    m2      = (pend_b_r && (rd_b < m1)) ? rd_b : m1;
    more    = lo_r < hi_r;
    hi_m1   = hi_r - PW'(1);
    acc_ext = 64'(acc_r);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == LAST_NODE) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.cmd == CMD_QUERY) state_nxt = ST_QRY;
          else if (ld_ok)               state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (parent == ROOT) state_nxt = ST_IDLE;
      end
      ST_QRY: begin
        if (!more) state_nxt = ST_QOUT;
      end
      ST_QOUT: begin
        if (res_ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs, memory accesses and datapath register updates
  always_comb begin
    in_ready      = 1'b0;
    res_valid     = 1'b0;
    res_data      = '0;
    mem_wr_en     = 1'b0;
    mem_wr_addr   = clr_r;
    mem_wr_data   = LARGEST;
    mem_rd_a_addr = '0;
    mem_rd_b_addr = '0;
    clr_nxt       = clr_r;
    cur_nxt       = cur_r;
    val_nxt       = val_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    acc_nxt       = acc_r;
    pend_a_nxt    = 1'b0;
    pend_b_nxt    = 1'b0;
    empty_nxt     = empty_r;
    case (state_r)
      ST_CLEAR: begin
        mem_wr_en = 1'b1;
        clr_nxt   = clr_r + NW'(1);
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_data.cmd == CMD_QUERY) begin
            lo_nxt    = lo_init;
            hi_nxt    = hi_init;
            acc_nxt   = LARGEST;
            empty_nxt = q_empty;
          end else if (ld_ok) begin
            // write the leaf and fetch its sibling
            mem_wr_en     = 1'b1;
            mem_wr_addr   = leaf;
            mem_wr_data   = val_w;
            mem_rd_a_addr = leaf ^ NW'(1);
            cur_nxt       = leaf;
            val_nxt       = val_w;
          end
        end
      end
      ST_UPD: begin
        // write the parent, fetch the parent's sibling
        mem_wr_en     = 1'b1;
        mem_wr_addr   = parent;
        mem_wr_data   = upd_min;
        mem_rd_a_addr = parent ^ NW'(1);
        cur_nxt       = parent;
        val_nxt       = upd_min;
      end
      ST_QRY: begin
        acc_nxt = m2;
        if (more) begin
          mem_rd_a_addr = lo_r[NW-1:0];
          mem_rd_b_addr = hi_m1[NW-1:0];
          pend_a_nxt    = lo_r[0];
          pend_b_nxt    = hi_r[0];
          lo_nxt        = (lo_r + PW'(lo_r[0])) >> 1;
          hi_nxt        = hi_r >> 1;
        end
      end
      ST_QOUT: begin
        res_valid            = 1'b1;
        res_data.minimum     = acc_ext[DATA_BITS-1:0];
        res_data.empty_range = empty_r;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      clr_r    <= '0;
      pend_a_r <= 1'b0;
      pend_b_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      pend_a_r <= pend_a_nxt;
      pend_b_r <= pend_b_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    val_r   <= val_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    acc_r   <= acc_nxt;
    empty_r <= empty_nxt;
  end

endmodule
